FILE: sv/phmt_pkg.sv
// Package for the pixel hit merge table: entry layout, sequencer states
// and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package phmt_pkg;

    // Field widths fixed by the hit and result formats
    localparam int SENSOR_W = 16;
    localparam int FE_W     = 4;
    localparam int COL_W    = 8;
    localparam int ROW_W    = 8;
    localparam int QIN_W    = 20;
    localparam int QSUM_W   = 24;
    localparam int SRC_W    = 16;
    localparam int HITS_W   = 8;
    localparam int DROP_W   = 16;

    // Stream widths, packed to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 104;

    // Mode codes carried on the input tuser
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_id;
        logic [FE_W-1:0]     front_end;
        logic [COL_W-1:0]    column;
        logic [ROW_W-1:0]    row;
    } t_key;

    // One stored table entry
    typedef struct packed {
        t_key              key;
        logic [QSUM_W-1:0] charge;
        logic [SRC_W-1:0]  first_source;
        logic [HITS_W-1:0] hits;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN_RD,
        ST_DRAIN_LD,
        ST_DRAIN_EMPTY
    } t_state;

endpackage

FILE: sv/pixel_hit_merge_table.sv
// Pixel hit merge table: key search, merge/append and drain sequencer
// around one entry memory. Depends on phmt_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata: hit fields; tuser: mode
// m_axis    out        m_axis_tvalid/tready       tdata: entry; tuser: empty; tlast
//
// An add walks the stored entries one per cycle through the registered memory
// read port until a match is merged into its entry or the scan ends, when the hit
// is appended or, on a full table, dropped; the sequencer then returns to idle.
// A drain reads each entry, then loads it into the output register, the load
// waiting while the output is stalled; an empty drain loads one empty result.
// s_axis_tready is high only while the sequencer is idle; a result may still
// wait in the output register then. Synchronous active-low reset clears the
// occupancy, drop counter and control; the memory keeps its contents.
module pixel_hit_merge_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] sensor_id, [19:16] front_end, [27:20] column, [35:28] row,
    // [55:36] charge, [71:56] mc_index
    input  logic [phmt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] out_sensor_id, [19:16] out_front_end, [27:20] out_column,
    // [35:28] out_row, [59:36] charge_sum, [75:60] first_source,
    // [83:76] hit_count, [99:84] dropped, [103:100] zero
    output logic [phmt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [0] empty_res
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // Control state
    phmt_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_occ, n_occ;
    logic [CW-1:0]    r_idx, n_idx;
    logic [IW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_rd_vld, n_rd_vld;
    logic [phmt_pkg::DROP_W-1:0] r_drop, n_drop;

    // Latched hit
    phmt_pkg::t_key              r_key;
    logic [phmt_pkg::QIN_W-1:0]  r_charge;
    logic [phmt_pkg::SRC_W-1:0]  r_src;

    // Output register
    logic                        r_out_vld, n_out_vld;
    phmt_pkg::t_entry            r_out, n_out;
    logic [phmt_pkg::DROP_W-1:0] r_out_drop, n_out_drop;
    logic                        r_out_empty, n_out_empty;
    logic                        r_out_last, n_out_last;

    // Memory
    phmt_pkg::t_entry r_mem [TABLE_DEPTH];
    phmt_pkg::t_entry r_rd_word;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    phmt_pkg::t_entry wr_word;
    logic [IW-1:0]    rd_addr;

    logic in_acc;
    logic out_free;
    logic hit_match;
    logic scan_done;
    logic [phmt_pkg::QSUM_W:0] sum;
    phmt_pkg::t_entry merged;
    phmt_pkg::t_entry fresh;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_vld || m_axis_tready;
    assign rd_addr   = r_idx[IW-1:0];
    assign hit_match = r_rd_vld && (r_rd_word.key == r_key);
    assign scan_done = !r_rd_vld && (r_idx >= r_occ);

    // Saturating merge of the latched hit into the entry just read
    always_comb begin
        sum = {1'b0, r_rd_word.charge} +
              {{(phmt_pkg::QSUM_W + 1 - phmt_pkg::QIN_W){1'b0}}, r_charge};
        merged              = r_rd_word;
        merged.charge       = sum[phmt_pkg::QSUM_W] ? {phmt_pkg::QSUM_W{1'b1}}
                                                    : sum[phmt_pkg::QSUM_W-1:0];
        merged.hits         = (r_rd_word.hits == {phmt_pkg::HITS_W{1'b1}})
                              ? r_rd_word.hits : r_rd_word.hits + 1'b1;
        fresh.key           = r_key;
        fresh.charge        = {{(phmt_pkg::QSUM_W - phmt_pkg::QIN_W){1'b0}}, r_charge};
        fresh.first_source  = r_src;
        fresh.hits          = {{(phmt_pkg::HITS_W - 1){1'b0}}, 1'b1};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            phmt_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == phmt_pkg::MODE_ADD) begin
                        n_state = phmt_pkg::ST_SEARCH;
                    end else if (r_occ == '0) begin
                        n_state = phmt_pkg::ST_DRAIN_EMPTY;
                    end else begin
                        n_state = phmt_pkg::ST_DRAIN_RD;
                    end
                end
            end
            phmt_pkg::ST_SEARCH: begin
                if (hit_match || scan_done) begin
                    n_state = phmt_pkg::ST_IDLE;
                end
            end
            phmt_pkg::ST_DRAIN_RD: begin
                n_state = phmt_pkg::ST_DRAIN_LD;
            end
            phmt_pkg::ST_DRAIN_LD: begin
                if (out_free) begin
                    n_state = (r_idx + ONE_C == r_occ) ? phmt_pkg::ST_IDLE
                                                       : phmt_pkg::ST_DRAIN_RD;
                end
            end
            phmt_pkg::ST_DRAIN_EMPTY: begin
                if (out_free) begin
                    n_state = phmt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = phmt_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs of the sequencer
    always_comb begin
        s_axis_tready = (r_state == phmt_pkg::ST_IDLE);
        n_occ         = r_occ;
        n_idx         = r_idx;
        n_rd_idx      = r_rd_idx;
        n_rd_vld      = 1'b0;
        n_drop        = r_drop;
        n_out_vld     = (r_out_vld && !m_axis_tready);
        n_out         = r_out;
        n_out_drop    = r_out_drop;
        n_out_empty   = r_out_empty;
        n_out_last    = r_out_last;
        wr_en         = 1'b0;
        wr_addr       = r_rd_idx;
        wr_word       = merged;
        case (r_state)
            phmt_pkg::ST_IDLE: begin
                n_idx = '0;
            end
            phmt_pkg::ST_SEARCH: begin
                // advance the read pointer over the stored entries
                if (r_idx < r_occ) begin
                    n_idx    = r_idx + ONE_C;
                    n_rd_idx = r_idx[IW-1:0];
                    n_rd_vld = 1'b1;
                end
                if (hit_match) begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_idx;
                    wr_word = merged;
                end else if (scan_done) begin
                    // append, or drop when full
                    if (r_occ < DEPTH_C) begin
                        wr_en   = 1'b1;
                        wr_addr = r_occ[IW-1:0];
                        wr_word = fresh;
                        n_occ   = r_occ + ONE_C;
                    end else if (r_drop != {phmt_pkg::DROP_W{1'b1}}) begin
                        n_drop = r_drop + 1'b1;
                    end
                end
            end
            phmt_pkg::ST_DRAIN_RD: begin
            end
            phmt_pkg::ST_DRAIN_LD: begin
                if (out_free) begin
                    n_out_vld   = 1'b1;
                    n_out       = r_rd_word;
                    n_out_drop  = r_drop;
                    n_out_empty = 1'b0;
                    n_out_last  = (r_idx + ONE_C == r_occ);
                    if (r_idx + ONE_C == r_occ) begin
                        n_occ  = '0;
                        n_drop = '0;
                    end else begin
                        n_idx = r_idx + ONE_C;
                    end
                end
            end
            phmt_pkg::ST_DRAIN_EMPTY: begin
                if (out_free) begin
                    n_out_vld   = 1'b1;
                    n_out       = '0;
                    n_out_drop  = r_drop;
                    n_out_empty = 1'b1;
                    n_out_last  = 1'b1;
                    n_drop      = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= phmt_pkg::ST_IDLE;
            r_occ     <= '0;
            r_idx     <= '0;
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_drop    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_idx     <= n_idx;
            r_rd_idx  <= n_rd_idx;
            r_rd_vld  <= n_rd_vld;
            r_drop    <= n_drop;
            r_out_vld <= n_out_vld;
        end
    end

    // Latch the hit and the output payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key.sensor_id <= s_axis_tdata[15:0];
            r_key.front_end <= s_axis_tdata[19:16];
            r_key.column    <= s_axis_tdata[27:20];
            r_key.row       <= s_axis_tdata[35:28];
            r_charge        <= s_axis_tdata[55:36];
            r_src           <= s_axis_tdata[71:56];
        end
        r_out       <= n_out;
        r_out_drop  <= n_out_drop;
        r_out_empty <= n_out_empty;
        r_out_last  <= n_out_last;
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_word;
        end
        r_rd_word <= r_mem[rd_addr];
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'b0000, r_out_drop, r_out.hits, r_out.first_source,
                            r_out.charge, r_out.key.row, r_out.key.column,
                            r_out.key.front_end, r_out.key.sensor_id};
    assign m_axis_tuser  = r_out_empty;
    assign m_axis_tlast  = r_out_last;

    // Occupancy never passes the table depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= DEPTH_C)
        else $error("occupancy above table depth");

    // The search pointer stays within the stored entries
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == phmt_pkg::ST_SEARCH) |-> (r_idx <= r_occ))
        else $error("search pointer beyond occupancy");

    // Hits are dropped only while the table is full
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drop != '0) |-> (r_occ == DEPTH_C))
        else $error("drop counter set while table not full");

    // An empty-drain result is always the last of its drain
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_empty) |-> r_out_last)
        else $error("empty result without last marker");

    // A finished drain leaves the table cleared
    a_drain_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == phmt_pkg::ST_DRAIN_LD && out_free && (r_idx + ONE_C == r_occ))
        |=> (r_occ == '0 && r_drop == '0))
        else $error("table not cleared after drain");

endmodule
